// ===== rtl/lidar_ray_point_transform_assert.svh =====
// assertion macros for the lidar ray point transform
// used by the queue, front and back modules; expects clk and rst_n in scope
`ifndef LIDAR_RAY_POINT_TRANSFORM_ASSERT_SVH
`define LIDAR_RAY_POINT_TRANSFORM_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define LRPT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define LRPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LRPT_ASSERT_IMPL(lbl, ante, cons, msg)
`define LRPT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/lrpt_pkg.sv =====
// shared constants, types and helpers of the lidar ray point transform
// no dependencies; imported by every module of the block
package lrpt_pkg;

    // field formats
    localparam int DIR_FRAC_BITS = 15;
    localparam int RANGE_BITS    = 18;
    localparam int DIR_W         = DIR_FRAC_BITS + 1;
    localparam int ROW_W         = 3 * DIR_W;
    localparam int SHIFT_W       = 24;
    localparam int END_W         = 25;

    // datapath widths
    localparam int PROD_W  = 2 * DIR_W;
    localparam int ACC_W   = PROD_W + 1;
    localparam int MAG_W   = ACC_W - 1;
    localparam int WQ_W    = MAG_W + 1 - DIR_FRAC_BITS;
    localparam int RPROD_W = MAG_W + RANGE_BITS;
    localparam int EQ_W    = RPROD_W + 1 - 2 * DIR_FRAC_BITS;
    localparam int ESUM_A  = (EQ_W + 1 > SHIFT_W) ? EQ_W + 1 : SHIFT_W;
    localparam int ESUM_W  = ((ESUM_A > END_W) ? ESUM_A : END_W) + 1;

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = ROW_W;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW_X   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW_Y   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW_Z   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_X     = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_Y     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_Z     = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HIT_MIN     = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_HIT_MAX     = 4'd7;

    // register reset values
    localparam logic [ROW_W-1:0] ROT_ROW_X_RST = ROW_W'(64'h0000_0000_8000_0000);
    localparam logic [ROW_W-1:0] ROT_ROW_Y_RST = ROW_W'(64'h0000_0000_0000_8000);
    localparam logic [ROW_W-1:0] ROT_ROW_Z_RST = ROW_W'(64'h0000_0000_0000_7FFF);

    // stream packing
    localparam int IN_FIELDS_W  = RANGE_BITS + 3 * DIR_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int IN_USER_W    = 8;
    localparam int OUT_FIELDS_W = 3 * END_W + 3 * DIR_W + RANGE_BITS;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_USER_W   = 8;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [2:0][ROW_W-1:0]   rot_row;
        logic [2:0][SHIFT_W-1:0] shift;
        logic [RANGE_BITS-1:0]   hit_min;
        logic [RANGE_BITS-1:0]   hit_max;
    } cfg_t;

    typedef struct packed {
        logic [RANGE_BITS-1:0]  range;
        logic                   meas;
        logic                   hit;
        logic [2:0][DIR_W-1:0]  dir;
        logic [RANGE_BITS-1:0]  max_range;
    } ray_t;

    typedef struct packed {
        logic                   meas;
        logic                   hit;
        logic [2:0][END_W-1:0]  end_pt;
        logic [2:0][DIR_W-1:0]  wdir;
        logic [RANGE_BITS-1:0]  max_range;
    } res_t;

    // entry j of a packed rotation row, entry 0 in the high bits
    function automatic logic [DIR_W-1:0] rot_entry(input logic [ROW_W-1:0] row,
                                                   input logic [1:0] j);
        logic [1:0] pos;
        pos = 2'd2 - j;
        return row[pos * DIR_W +: DIR_W];
    endfunction

endpackage

// ===== rtl/lrpt_queue.sv =====
// short ray queue that decouples the classifying front from the arithmetic back
// depends on lrpt_pkg and the assertion macro header
`include "lidar_ray_point_transform_assert.svh"

module lrpt_queue
    import lrpt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  ray_t push_data,
    output logic full,
    input  logic pop,
    output logic pop_valid,
    output ray_t pop_data
);

    ray_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full      = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage write
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    `LRPT_ASSERT_IMPL(a_no_overflow, push, !full, "ray queue written while full")
    `LRPT_ASSERT_NEXT(a_fill_grows, push && !pop, count_reg == $past(count_reg) + 1'b1,
                      "ray queue fill count did not grow on a lone push")

endmodule

// ===== rtl/lrpt_front.sv =====
// front end: takes ray transactions, classifies them and keeps the frame maximum
// depends on lrpt_pkg and the assertion macro header
`include "lidar_ray_point_transform_assert.svh"

module lrpt_front
    import lrpt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [RANGE_BITS-1:0] range_mm,
    input  logic                  range_bad,
    input  logic [2:0][DIR_W-1:0] dir,
    input  logic                  frame_start,
    input  cfg_t                  cfg,
    input  logic                  queue_full,
    output logic                  push,
    output ray_t                  push_data
);

    logic [RANGE_BITS-1:0] max_reg, max_next;
    logic [RANGE_BITS-1:0] max_base;
    logic                  meas;
    logic                  hit;

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

    // classification and running maximum
    always_comb
    begin
        max_base = frame_start ? '0 : max_reg;
        meas     = (range_mm != '0) && !range_bad;
        hit      = meas && (range_mm >= cfg.hit_min) && (range_mm <= cfg.hit_max);
        max_next = max_reg;
        if (push)
        begin
            max_next = (hit && (range_mm > max_base)) ? range_mm : max_base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= '0;
        end
        else
        begin
            max_reg <= max_next;
        end
    end

    // queue entry
    always_comb
    begin
        push_data.range     = range_mm;
        push_data.meas      = meas;
        push_data.hit       = hit;
        push_data.dir       = dir;
        push_data.max_range = max_next;
    end

    `LRPT_ASSERT_NEXT(a_max_monotonic, push && !frame_start, max_reg >= $past(max_reg),
                      "frame maximum fell without a frame start")

endmodule

// ===== rtl/lrpt_back.sv =====
// back end: rotates a queued ray on a shared multiplier, then scales and translates it
// depends on lrpt_pkg and the assertion macro header
`include "lidar_ray_point_transform_assert.svh"

module lrpt_back
    import lrpt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic pop_valid,
    input  ray_t pop_data,
    output logic pop,
    input  cfg_t cfg,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_data
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MAC   = 2'd1;
    localparam logic [1:0] ST_SCALE = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    localparam logic signed [ESUM_W-1:0] END_HI = ESUM_W'((64'sd1 <<< (END_W - 1)) - 64'sd1);
    localparam logic signed [ESUM_W-1:0] END_LO = -END_HI - ESUM_W'(1);
    localparam logic [WQ_W-1:0] WQ_POS_MAX = WQ_W'((64'd1 << DIR_FRAC_BITS) - 64'd1);
    localparam logic [WQ_W-1:0] WQ_NEG_MAX = WQ_W'(64'd1 << DIR_FRAC_BITS);

    // control state
    logic [1:0] state_reg, state_next;
    logic [1:0] row_reg, row_next;
    logic [1:0] col_reg, col_next;
    logic       out_valid_reg, out_valid_next;

    // payload
    ray_t                     cur_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     neg_reg;
    logic [DIR_W-1:0]         wdir_tmp_reg;
    logic [RPROD_W-1:0]       rprod_reg;
    logic [END_W-1:0]         end_res_reg [2];
    logic [DIR_W-1:0]         wdir_res_reg [2];
    res_t                     out_reg;

    logic                     out_free;
    logic                     out_load;
    logic [1:0]               col_idx;
    logic signed [DIR_W-1:0]  rot_e;
    logic signed [DIR_W-1:0]  dir_e;
    logic signed [PROD_W-1:0] prod_c;
    logic signed [ACC_W-1:0]  acc_sum;
    logic [ACC_W-1:0]         mag_full;
    logic [MAG_W-1:0]         mag_c;
    logic [MAG_W:0]           wq_sum;
    logic [WQ_W-1:0]          wq_c;
    logic [DIR_W-1:0]         wdir_c;
    logic [RPROD_W-1:0]       rprod_c;
    logic [RPROD_W:0]         eq_sum;
    logic [EQ_W-1:0]          eq_c;
    logic signed [ESUM_W-1:0] eq_s;
    logic signed [ESUM_W-1:0] sh_s;
    logic signed [ESUM_W-1:0] esum;
    logic [END_W-1:0]         end_c;

    // multiply-accumulate operands for the current row and column
    always_comb
    begin
        col_idx = (col_reg == 2'd3) ? 2'd2 : col_reg;
        rot_e   = $signed(rot_entry(cfg.rot_row[row_reg], col_idx));
        dir_e   = $signed(cur_reg.dir[col_idx]);
        prod_c  = rot_e * dir_e;
        acc_sum = acc_reg + ACC_W'(prod_reg);
    end

    // world direction: magnitude, round half away from zero, saturate
    always_comb
    begin
        mag_full = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        mag_c    = mag_full[MAG_W-1:0];
        wq_sum   = {1'b0, mag_c} + (MAG_W+1)'(64'd1 << (DIR_FRAC_BITS - 1));
        wq_c     = wq_sum[MAG_W:DIR_FRAC_BITS];
        if (acc_reg[ACC_W-1])
        begin
            wdir_c = (wq_c > WQ_NEG_MAX) ? {1'b1, {(DIR_W-1){1'b0}}}
                                         : DIR_W'(-wq_c);
        end
        else
        begin
            wdir_c = (wq_c > WQ_POS_MAX) ? {1'b0, {(DIR_W-1){1'b1}}}
                                         : wq_c[DIR_W-1:0];
        end
        rprod_c = RPROD_W'(mag_c) * RPROD_W'(cur_reg.range);
    end

    // end point: round the scaled product, apply sign and translation, saturate
    always_comb
    begin
        eq_sum = {1'b0, rprod_reg} + (RPROD_W+1)'(64'd1 << (2 * DIR_FRAC_BITS - 1));
        eq_c   = eq_sum[RPROD_W:2*DIR_FRAC_BITS];
        eq_s   = neg_reg ? -$signed(ESUM_W'(eq_c)) : $signed(ESUM_W'(eq_c));
        sh_s   = ESUM_W'($signed(cfg.shift[row_reg]));
        esum   = eq_s + sh_s;
        priority if (esum > END_HI)
        begin
            end_c = END_HI[END_W-1:0];
        end
        else if (esum < END_LO)
        begin
            end_c = END_LO[END_W-1:0];
        end
        else
        begin
            end_c = esum[END_W-1:0];
        end
    end

    // sequencer
    always_comb
    begin
        out_free       = !out_valid_reg || out_ready;
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        pop            = 1'b0;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    pop        = 1'b1;
                    row_next   = 2'd0;
                    col_next   = 2'd0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                col_next = col_reg + 1'b1;
                if (col_reg == 2'd3)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (row_reg != 2'd2)
                begin
                    row_next   = row_reg + 1'b1;
                    state_next = ST_MAC;
                end
                else if (out_free)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_reg       <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= pop_data;
        end
        if (state_reg == ST_MAC)
        begin
            if (col_reg != 2'd3)
            begin
                prod_reg <= prod_c;
            end
            acc_reg <= (col_reg == 2'd0) ? '0 : acc_sum;
        end
        if (state_reg == ST_SCALE)
        begin
            neg_reg      <= acc_reg[ACC_W-1];
            wdir_tmp_reg <= wdir_c;
            rprod_reg    <= rprod_c;
        end
        if ((state_reg == ST_FIN) && (row_reg != 2'd2))
        begin
            end_res_reg[row_reg[0]]  <= end_c;
            wdir_res_reg[row_reg[0]] <= wdir_tmp_reg;
        end
        if (out_load)
        begin
            out_reg.meas      <= cur_reg.meas;
            out_reg.hit       <= cur_reg.hit;
            out_reg.max_range <= cur_reg.max_range;
            if (cur_reg.meas)
            begin
                out_reg.end_pt <= {end_c, end_res_reg[1], end_res_reg[0]};
                out_reg.wdir   <= {wdir_tmp_reg, wdir_res_reg[1], wdir_res_reg[0]};
            end
            else
            begin
                out_reg.end_pt <= '0;
                out_reg.wdir   <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `LRPT_ASSERT_NEXT(a_pop_starts_mac, pop, (state_reg == ST_MAC) && (col_reg == 2'd0),
                      "ray taken from the queue without starting the row sequence")
    `LRPT_ASSERT_IMPL(a_unmeasurable_zero, out_valid_reg && !out_reg.meas,
                      (out_reg.end_pt == '0) && (out_reg.wdir == '0) && !out_reg.hit,
                      "unmeasurable ray produced a non-zero result")

endmodule

// ===== rtl/lidar_ray_point_transform.sv =====
// top level of the lidar ray point transform: configuration registers and stream ports
// depends on lrpt_pkg, lrpt_front, lrpt_queue and lrpt_back
//
// channel   direction  handshake            payload
// s_*       in         s_tvalid / s_tready  one lidar ray
// m_*       out        m_tvalid / m_tready  one transformed ray
// cfg_*     in         cfg_we               register index and value
//
// in the back end a ray first leaves the queue, then each coordinate takes three
// multiply-accumulate steps and a drain on the one shared DIR_W x DIR_W
// multiplier, one range scaling multiply and one rounding step
// the front takes a ray every cycle until the four-entry queue fills
// reset clears the queue, sequencer and frame maximum and presets the config registers
// a result waiting on m_tready holds only the final step of the next ray

module lidar_ray_point_transform
    import lrpt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // range_mm, dir_x, dir_y, dir_z, zero padding
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // range_bad, frame_start, zero padding
    input  logic [IN_USER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // end_x, end_y, end_z, wdir_x, wdir_y, wdir_z, max_hit_range, zero padding
    output logic [OUT_DATA_W-1:0] m_tdata,
    // measurable, is_hit, zero padding
    output logic [OUT_USER_W-1:0] m_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t                  cfg_reg;
    logic [2:0][DIR_W-1:0] in_dir;
    logic                  push;
    ray_t                  push_data;
    logic                  queue_full;
    logic                  pop;
    logic                  pop_valid;
    ray_t                  pop_data;
    res_t                  res;

    // configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rot_row[0] <= ROT_ROW_X_RST;
            cfg_reg.rot_row[1] <= ROT_ROW_Y_RST;
            cfg_reg.rot_row[2] <= ROT_ROW_Z_RST;
            cfg_reg.shift      <= '0;
            cfg_reg.hit_min    <= '0;
            cfg_reg.hit_max    <= '1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ROT_ROW_X: cfg_reg.rot_row[0] <= cfg_data[ROW_W-1:0];
                CFG_ROT_ROW_Y: cfg_reg.rot_row[1] <= cfg_data[ROW_W-1:0];
                CFG_ROT_ROW_Z: cfg_reg.rot_row[2] <= cfg_data[ROW_W-1:0];
                CFG_SHIFT_X:   cfg_reg.shift[0]   <= cfg_data[SHIFT_W-1:0];
                CFG_SHIFT_Y:   cfg_reg.shift[1]   <= cfg_data[SHIFT_W-1:0];
                CFG_SHIFT_Z:   cfg_reg.shift[2]   <= cfg_data[SHIFT_W-1:0];
                CFG_HIT_MIN:   cfg_reg.hit_min    <= cfg_data[RANGE_BITS-1:0];
                CFG_HIT_MAX:   cfg_reg.hit_max    <= cfg_data[RANGE_BITS-1:0];
                default:       ;
            endcase
        end
    end

    // input unpacking
    assign in_dir = s_tdata[IN_FIELDS_W-1:RANGE_BITS];

    lrpt_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .range_mm    (s_tdata[RANGE_BITS-1:0]),
        .range_bad   (s_tuser[0]),
        .dir         (in_dir),
        .frame_start (s_tuser[1]),
        .cfg         (cfg_reg),
        .queue_full  (queue_full),
        .push        (push),
        .push_data   (push_data)
    );

    lrpt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_data  (pop_data)
    );

    lrpt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .pop       (pop),
        .cfg       (cfg_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    // output packing
    assign m_tdata = OUT_DATA_W'({res.max_range, res.wdir, res.end_pt});
    assign m_tuser = OUT_USER_W'({res.hit, res.meas});

endmodule
